>>> hdl/rtdc_pkg.sv
// Shared types, constants and helpers for the RTD code-to-temperature unit.
`default_nettype none
package rtdc_pkg;

	localparam int CODE_BITS    = 24;
	localparam int NEWTON_STEPS = 20;
	localparam int ITER_W       = $clog2(NEWTON_STEPS + 1);

	localparam int REF_W   = 24;
	localparam int NOM_W   = 20;
	localparam int COEF_W  = 33;
	localparam int RES_W   = 33;
	localparam int TEMP_W  = 19;
	localparam int PROD_W  = CODE_BITS + REF_W + 1;
	localparam int DIV_W   = 80;
	localparam int WORD_W  = 64;
	localparam int SHIFT_W = 6;
	localparam int CNT_W   = 7;

	localparam logic [REF_W-1:0]         REF_RST   = 24'd2099200;
	localparam logic [NOM_W-1:0]         NOM_RST   = 20'd256000;
	localparam logic [COEF_W-1:0]        COEF_A_RST = 33'd4297230000;
	localparam logic signed [COEF_W-1:0] COEF_B_RST = -33'sd162552000;
	localparam logic signed [COEF_W-1:0] COEF_C_RST = -33'sd77163000;

	localparam logic signed [TEMP_W-1:0] T_MAX = 19'sd262143;
	localparam logic signed [TEMP_W-1:0] T_MIN = -19'sd262144;

	localparam logic [WORD_W-1:0] DERIV_TINY = 64'd32;
	localparam logic [36:0]       STEP_SMALL = 37'd65;

	typedef enum logic [2:0] {
		CFG_REF_RES = 3'd0,
		CFG_NOM_RES = 3'd1,
		CFG_COEF_A  = 3'd2,
		CFG_COEF_B  = 3'd3,
		CFG_COEF_C  = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		AR_MUL,
		AR_DIV,
		AR_SQRT
	} ar_op_t;

	typedef enum logic [1:0] {
		AR_IDLE,
		AR_RUN,
		AR_FIN,
		AR_DONE
	} ar_state_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RES1,
		ST_RES2,
		ST_UXQ,
		ST_UAA,
		ST_UBX,
		ST_UCHK,
		ST_UVTX,
		ST_USQ,
		ST_UDEN,
		ST_UDIV,
		ST_LY,
		ST_LT2,
		ST_LT3,
		ST_LT4,
		ST_LG1,
		ST_LG2,
		ST_LG3,
		ST_LG4,
		ST_LD1,
		ST_LD2,
		ST_LCHK,
		ST_LSTEP,
		ST_LEND,
		ST_FIN
	} st_t;

	// mul: opa[63:0] and opb signed, result floor(a*b / 2^shift) saturated
	// div: unsigned opa / opb; sqrt: floor(sqrt(opa[63:0]))
	typedef struct packed {
		logic               start;
		ar_op_t             op;
		logic [DIV_W-1:0]   opa;
		logic [WORD_W-1:0]  opb;
		logic [SHIFT_W-1:0] shift;
	} ar_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] result;
	} ar_stat_t;

	function automatic logic [WORD_W-1:0] mag64(input logic signed [WORD_W-1:0] v);
		return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
	endfunction

endpackage
`default_nettype wire

>>> hdl/rtdc_arith.sv
// Bit-serial multiply, divide and square root unit shared by the sequencer.
`default_nettype none
module rtdc_arith (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtdc_pkg::ar_req_t req,
	output rtdc_pkg::ar_stat_t     stat
);

	rtdc_pkg::ar_state_t state_q, state_d;
	rtdc_pkg::ar_op_t    op_q;
	logic [rtdc_pkg::SHIFT_W-1:0] shift_q;
	logic                         neg_q;
	logic [rtdc_pkg::CNT_W-1:0]   cnt_q;
	// x: multiplier/product low, dividend/quotient, radicand
	// y: product high, remainder, root;  z: multiplicand, divisor, root bit
	logic [rtdc_pkg::DIV_W-1:0]   x_q;
	logic [rtdc_pkg::WORD_W-1:0]  y_q;
	logic [rtdc_pkg::WORD_W-1:0]  z_q;
	logic [rtdc_pkg::DIV_W-1:0]   res_q;

	logic [64:0]  mul_sum;
	logic [64:0]  div_trial;
	logic         div_ge;
	logic [64:0]  div_rem;
	logic [63:0]  sq_rb;
	logic         sq_ge;
	logic [127:0] prod;
	logic [127:0] prod_rnd;
	logic [127:0] prod_sh;
	logic [63:0]  lim;
	logic [63:0]  mag_r;
	logic [63:0]  mul_out;

	assign mul_sum   = {1'b0, y_q} + (x_q[0] ? {1'b0, z_q} : 65'd0);
	assign div_trial = {y_q, x_q[rtdc_pkg::DIV_W-1]};
	assign div_ge    = div_trial >= {1'b0, z_q};
	assign div_rem   = div_ge ? div_trial - {1'b0, z_q} : div_trial;
	assign sq_rb     = y_q + z_q;
	assign sq_ge     = x_q[63:0] >= sq_rb;

	assign prod     = {y_q, x_q[63:0]};
	assign prod_rnd = prod + (neg_q ? ((128'd1 << shift_q) - 128'd1) : 128'd0);
	assign prod_sh  = prod_rnd >> shift_q;
	assign lim      = neg_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	assign mag_r    = ((|prod_sh[127:64]) || (prod_sh[63:0] > lim)) ? lim : prod_sh[63:0];
	assign mul_out  = neg_q ? 64'(-mag_r) : mag_r;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtdc_pkg::AR_IDLE: if (req.start) state_d = rtdc_pkg::AR_RUN;
			rtdc_pkg::AR_RUN:  if (cnt_q == rtdc_pkg::CNT_W'(1)) state_d = rtdc_pkg::AR_FIN;
			rtdc_pkg::AR_FIN:  state_d = rtdc_pkg::AR_DONE;
			rtdc_pkg::AR_DONE: state_d = rtdc_pkg::AR_IDLE;
			default:           state_d = rtdc_pkg::AR_IDLE;
		endcase
	end

	always_comb begin
		stat.done   = (state_q == rtdc_pkg::AR_DONE);
		stat.result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtdc_pkg::AR_IDLE;
			op_q    <= rtdc_pkg::AR_MUL;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rtdc_pkg::AR_IDLE && req.start) begin
				op_q <= req.op;
				case (req.op)
					rtdc_pkg::AR_MUL:  cnt_q <= rtdc_pkg::CNT_W'(64);
					rtdc_pkg::AR_DIV:  cnt_q <= rtdc_pkg::CNT_W'(rtdc_pkg::DIV_W);
					default:           cnt_q <= rtdc_pkg::CNT_W'(32);
				endcase
			end else if (state_q == rtdc_pkg::AR_RUN) begin
				cnt_q <= cnt_q - rtdc_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtdc_pkg::AR_IDLE && req.start) begin
			shift_q <= req.shift;
			neg_q   <= req.opa[63] ^ req.opb[63];
			y_q     <= '0;
			case (req.op)
				rtdc_pkg::AR_MUL: begin
					x_q <= {16'd0, rtdc_pkg::mag64(req.opb)};
					z_q <= rtdc_pkg::mag64(req.opa[63:0]);
				end
				rtdc_pkg::AR_DIV: begin
					x_q <= req.opa;
					z_q <= req.opb;
				end
				default: begin
					x_q <= {16'd0, req.opa[63:0]};
					z_q <= 64'd1 << 62;
				end
			endcase
		end else if (state_q == rtdc_pkg::AR_RUN) begin
			case (op_q)
				rtdc_pkg::AR_MUL: begin
					y_q       <= mul_sum[64:1];
					x_q[63:0] <= {mul_sum[0], x_q[63:1]};
				end
				rtdc_pkg::AR_DIV: begin
					y_q <= div_rem[63:0];
					x_q <= {x_q[rtdc_pkg::DIV_W-2:0], div_ge};
				end
				default: begin
					if (sq_ge) begin
						x_q[63:0] <= x_q[63:0] - sq_rb;
						y_q       <= (y_q >> 1) + z_q;
					end else begin
						y_q <= y_q >> 1;
					end
					z_q <= z_q >> 2;
				end
			endcase
		end
		if (state_q == rtdc_pkg::AR_FIN) begin
			case (op_q)
				rtdc_pkg::AR_MUL: res_q <= {{16{mul_out[63]}}, mul_out};
				rtdc_pkg::AR_DIV: res_q <= x_q;
				default:          res_q <= {16'd0, y_q};
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/rtd_code_to_temperature_unit.sv
// RTD code-to-temperature unit: sequencer, configuration and result register.
//
// Input channel (in_valid/in_ready, raw_code) takes one signed converter
// code per beat. The output channel (out_valid/out_ready) returns the sensor
// resistance, the temperature in 1/256 degC, the path taken and a clamp flag.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready and writes one register per beat; write it only while idle.
// One item is worked at a time through a shared bit-serial unit. Below zero,
// each Newton step costs nine multiplies and one divide, and an item takes up
// to NEWTON_STEPS steps, fewer when the step converges early or the derivative
// is too small. The next item is taken as soon as the result sits in the
// output register; a stalled receiver holds the result and stops the
// sequencer only at its final step. Reset clears the sequencer, drops any
// pending result and loads the default coefficients; no clearing pass is
// needed.
`default_nettype none
module rtd_code_to_temperature_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [rtdc_pkg::CODE_BITS-1:0] raw_code,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [rtdc_pkg::RES_W-1:0]        resistance,
	output logic signed [rtdc_pkg::TEMP_W-1:0]       temperature,
	output logic                                     below_zero_path,
	output logic                                     saturated,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [2:0]                          cfg_index,
	input  wire logic [rtdc_pkg::COEF_W-1:0]         cfg_data
);

	rtdc_pkg::st_t      state_q, state_d;
	rtdc_pkg::ar_req_t  ar_req;
	rtdc_pkg::ar_stat_t ar_stat;

	logic [rtdc_pkg::REF_W-1:0]         ref_q;
	logic [rtdc_pkg::NOM_W-1:0]         nom_q;
	logic [rtdc_pkg::COEF_W-1:0]        coef_a_q;
	logic signed [rtdc_pkg::COEF_W-1:0] coef_b_q;
	logic signed [rtdc_pkg::COEF_W-1:0] coef_c_q;

	logic signed [rtdc_pkg::CODE_BITS-1:0] code_q;
	logic signed [rtdc_pkg::PROD_W-1:0]    prod_q;
	logic signed [rtdc_pkg::RES_W-1:0]     res_q;
	logic                                  below_q;
	logic [27:0]                           xq_q;
	logic signed [28:0]                    tq_q;
	logic signed [51:0]                    y_q;
	logic signed [39:0]                    t2_q;
	logic signed [50:0]                    t3_q;
	logic signed [61:0]                    t4_q;
	logic signed [63:0]                    acc_q;
	logic signed [63:0]                    g_q;
	logic signed [63:0]                    dp_q;
	logic signed [56:0]                    temp_q;
	logic [rtdc_pkg::ITER_W-1:0]           iter_q;
	logic                                  issued_q;

	logic signed [rtdc_pkg::RES_W-1:0]  out_res_q;
	logic signed [rtdc_pkg::TEMP_W-1:0] out_temp_q;
	logic                               out_below_q;
	logic                               out_sat_q;
	logic                               out_valid_q;

	logic [rtdc_pkg::NOM_W-1:0]         r0;
	logic signed [rtdc_pkg::RES_W-1:0]  r0_ext;
	logic signed [rtdc_pkg::PROD_W-1:0] prod_rnd;
	logic signed [rtdc_pkg::PROD_W-1:0] res_full;
	logic signed [rtdc_pkg::RES_W-1:0]  res_next;
	logic                               below_next;
	logic [32:0]                        d_up;
	logic                               up_big;
	logic [32:0]                        d_lo;
	logic [32:0]                        r0x4;
	logic [32:0]                        d_cap;
	logic [32:0]                        abs_b;
	logic signed [63:0]                 mulres;
	logic signed [63:0]                 t3x100;
	logic signed [63:0]                 t2x300;
	logic signed [63:0]                 dterm;
	logic signed [63:0]                 tq_x2;
	logic [63:0]                        abs_g;
	logic [63:0]                        abs_dp;
	logic [36:0]                        step_v;
	logic                               step_small;
	logic                               last_iter;
	logic signed [38:0]                 tq_sum;
	logic signed [28:0]                 tq_next;
	logic signed [29:0]                 t_rnd;
	logic                               fin_load;
	logic                               op_state;

	assign r0       = (nom_q == '0) ? rtdc_pkg::NOM_W'(1) : nom_q;
	assign r0_ext   = $signed({13'd0, r0});
	assign prod_rnd = prod_q + $signed(rtdc_pkg::PROD_W'(1) << (rtdc_pkg::CODE_BITS - 2));
	assign res_full = prod_rnd >>> (rtdc_pkg::CODE_BITS - 1);
	assign res_next = res_full[rtdc_pkg::RES_W-1:0];
	assign below_next = res_next < r0_ext;

	assign d_up   = res_q - r0_ext;
	assign up_big = d_up >= {8'd0, r0, 5'd0};
	assign d_lo   = r0_ext - res_q;
	assign r0x4   = {11'd0, r0, 2'd0};
	assign d_cap  = (d_lo > r0x4) ? r0x4 : d_lo;
	assign abs_b  = coef_b_q[32] ? 33'(-coef_b_q) : coef_b_q;

	assign mulres = ar_stat.result[63:0];
	assign t3x100 = (64'(t3_q) <<< 6) + (64'(t3_q) <<< 5) + (64'(t3_q) <<< 2);
	assign t2x300 = (64'(t2_q) <<< 8) + (64'(t2_q) <<< 5) + (64'(t2_q) <<< 3)
			+ (64'(t2_q) <<< 2);
	assign dterm  = (64'(t3_q) <<< 2) - t2x300;
	assign tq_x2  = 64'(tq_q) <<< 1;
	assign abs_g  = rtdc_pkg::mag64(g_q);
	assign abs_dp = rtdc_pkg::mag64(dp_q);

	// cap the Newton step at 2^20 degC
	assign step_v     = (|ar_stat.result[79:36]) ? (37'd1 << 36) : ar_stat.result[36:0];
	assign step_small = step_v <= rtdc_pkg::STEP_SMALL;
	assign last_iter  = iter_q == rtdc_pkg::ITER_W'(rtdc_pkg::NEWTON_STEPS - 1);
	assign tq_sum     = (g_q[63] == dp_q[63]) ? 39'(tq_q) - $signed({2'b0, step_v})
	                                          : 39'(tq_q) + $signed({2'b0, step_v});
	always_comb begin
		if (tq_sum > 39'sd134217728)       tq_next = 29'sd134217728;
		else if (tq_sum < -39'sd134217728) tq_next = -29'sd134217728;
		else                               tq_next = tq_sum[28:0];
	end
	assign t_rnd = (30'(tq_q) + 30'sd128) >>> 8;

	assign fin_load = (state_q == rtdc_pkg::ST_FIN) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rtdc_pkg::ST_IDLE:  if (in_valid) state_d = rtdc_pkg::ST_RES1;
			rtdc_pkg::ST_RES1:  state_d = rtdc_pkg::ST_RES2;
			rtdc_pkg::ST_RES2:  state_d = below_next ? rtdc_pkg::ST_LY : rtdc_pkg::ST_UXQ;
			rtdc_pkg::ST_UXQ:   if (up_big || ar_stat.done) state_d = rtdc_pkg::ST_UAA;
			rtdc_pkg::ST_UAA:   if (ar_stat.done) state_d = rtdc_pkg::ST_UBX;
			rtdc_pkg::ST_UBX:   if (ar_stat.done) state_d = rtdc_pkg::ST_UCHK;
			rtdc_pkg::ST_UCHK:  state_d = acc_q[63] ? rtdc_pkg::ST_UVTX : rtdc_pkg::ST_USQ;
			rtdc_pkg::ST_UVTX:  if (ar_stat.done) state_d = rtdc_pkg::ST_FIN;
			rtdc_pkg::ST_USQ:   if (ar_stat.done) state_d = rtdc_pkg::ST_UDEN;
			rtdc_pkg::ST_UDEN:  state_d = (acc_q == '0) ? rtdc_pkg::ST_FIN : rtdc_pkg::ST_UDIV;
			rtdc_pkg::ST_UDIV:  if (ar_stat.done) state_d = rtdc_pkg::ST_FIN;
			rtdc_pkg::ST_LY:    if (ar_stat.done) state_d = rtdc_pkg::ST_LT2;
			rtdc_pkg::ST_LT2:   if (ar_stat.done) state_d = rtdc_pkg::ST_LT3;
			rtdc_pkg::ST_LT3:   if (ar_stat.done) state_d = rtdc_pkg::ST_LT4;
			rtdc_pkg::ST_LT4:   if (ar_stat.done) state_d = rtdc_pkg::ST_LG1;
			rtdc_pkg::ST_LG1:   if (ar_stat.done) state_d = rtdc_pkg::ST_LG2;
			rtdc_pkg::ST_LG2:   if (ar_stat.done) state_d = rtdc_pkg::ST_LG3;
			rtdc_pkg::ST_LG3:   if (ar_stat.done) state_d = rtdc_pkg::ST_LG4;
			rtdc_pkg::ST_LG4:   if (ar_stat.done) state_d = rtdc_pkg::ST_LD1;
			rtdc_pkg::ST_LD1:   if (ar_stat.done) state_d = rtdc_pkg::ST_LD2;
			rtdc_pkg::ST_LD2:   if (ar_stat.done) state_d = rtdc_pkg::ST_LCHK;
			rtdc_pkg::ST_LCHK:  state_d = (abs_dp < rtdc_pkg::DERIV_TINY) ? rtdc_pkg::ST_LEND
			                                                           : rtdc_pkg::ST_LSTEP;
			rtdc_pkg::ST_LSTEP: if (ar_stat.done)
				state_d = (step_small || last_iter) ? rtdc_pkg::ST_LEND : rtdc_pkg::ST_LT2;
			rtdc_pkg::ST_LEND:  state_d = rtdc_pkg::ST_FIN;
			rtdc_pkg::ST_FIN:   if (fin_load) state_d = rtdc_pkg::ST_IDLE;
			default:            state_d = rtdc_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake and arithmetic requests
	always_comb begin
		in_ready  = (state_q == rtdc_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		op_state  = 1'b1;
		ar_req    = '0;
		unique case (state_q)
			rtdc_pkg::ST_UXQ: begin
				ar_req.op  = rtdc_pkg::AR_DIV;
				ar_req.opa = rtdc_pkg::DIV_W'(d_up) << 22;
				ar_req.opb = 64'(r0);
				op_state   = !up_big;
			end
			rtdc_pkg::ST_UAA: begin
				ar_req.opa   = rtdc_pkg::DIV_W'(coef_a_q);
				ar_req.opb   = 64'(coef_a_q);
				ar_req.shift = 6'd10;
			end
			rtdc_pkg::ST_UBX: begin
				ar_req.opa = {16'd0, 64'(coef_b_q)};
				ar_req.opb = 64'(xq_q);
			end
			rtdc_pkg::ST_UVTX: begin
				ar_req.op  = rtdc_pkg::AR_DIV;
				ar_req.opa = (rtdc_pkg::DIV_W'(coef_a_q) << 15) + rtdc_pkg::DIV_W'(abs_b >> 1);
				ar_req.opb = 64'(abs_b);
			end
			rtdc_pkg::ST_USQ: begin
				ar_req.op  = rtdc_pkg::AR_SQRT;
				ar_req.opa = {16'd0, acc_q};
			end
			rtdc_pkg::ST_UDIV: begin
				ar_req.op  = rtdc_pkg::AR_DIV;
				ar_req.opa = (rtdc_pkg::DIV_W'(xq_q) << 27) + rtdc_pkg::DIV_W'(acc_q[63:1]);
				ar_req.opb = acc_q;
			end
			rtdc_pkg::ST_LY: begin
				ar_req.op  = rtdc_pkg::AR_DIV;
				ar_req.opa = rtdc_pkg::DIV_W'(d_cap) << 48;
				ar_req.opb = 64'(r0);
			end
			rtdc_pkg::ST_LT2: begin
				ar_req.opa   = {16'd0, 64'(tq_q)};
				ar_req.opb   = 64'(tq_q);
				ar_req.shift = 6'd16;
			end
			rtdc_pkg::ST_LT3: begin
				ar_req.opa   = {16'd0, 64'(t2_q)};
				ar_req.opb   = 64'(tq_q);
				ar_req.shift = 6'd16;
			end
			rtdc_pkg::ST_LT4: begin
				ar_req.opa   = {16'd0, 64'(t3_q)};
				ar_req.opb   = 64'(tq_q);
				ar_req.shift = 6'd16;
			end
			rtdc_pkg::ST_LG1: begin
				ar_req.opa   = rtdc_pkg::DIV_W'(coef_a_q);
				ar_req.opb   = 64'(tq_q);
				ar_req.shift = 6'd8;
			end
			rtdc_pkg::ST_LG2: begin
				ar_req.opa   = {16'd0, 64'(coef_b_q)};
				ar_req.opb   = 64'(t2_q);
				ar_req.shift = 6'd16;
			end
			rtdc_pkg::ST_LG3: begin
				ar_req.opa   = {16'd0, 64'(coef_c_q)};
				ar_req.opb   = 64'(t4_q);
				ar_req.shift = 6'd32;
			end
			rtdc_pkg::ST_LG4: begin
				ar_req.opa   = {16'd0, 64'(coef_c_q)};
				ar_req.opb   = t3x100;
				ar_req.shift = 6'd32;
			end
			rtdc_pkg::ST_LD1: begin
				ar_req.opa   = {16'd0, 64'(coef_b_q)};
				ar_req.opb   = tq_x2;
				ar_req.shift = 6'd16;
			end
			rtdc_pkg::ST_LD2: begin
				ar_req.opa   = {16'd0, 64'(coef_c_q)};
				ar_req.opb   = dterm;
				ar_req.shift = 6'd32;
			end
			rtdc_pkg::ST_LSTEP: begin
				ar_req.op  = rtdc_pkg::AR_DIV;
				ar_req.opa = rtdc_pkg::DIV_W'(abs_g) << 16;
				ar_req.opb = abs_dp;
			end
			default: op_state = 1'b0;
		endcase
		ar_req.start = op_state && !issued_q;
	end

	rtdc_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.stat   (ar_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtdc_pkg::ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
			ref_q       <= rtdc_pkg::REF_RST;
			nom_q       <= rtdc_pkg::NOM_RST;
			coef_a_q    <= rtdc_pkg::COEF_A_RST;
			coef_b_q    <= rtdc_pkg::COEF_B_RST;
			coef_c_q    <= rtdc_pkg::COEF_C_RST;
		end else begin
			state_q <= state_d;
			if (ar_stat.done)      issued_q <= 1'b0;
			else if (ar_req.start) issued_q <= 1'b1;
			if (fin_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (state_q == rtdc_pkg::ST_RES2) begin
				iter_q <= '0;
			end else if (state_q == rtdc_pkg::ST_LSTEP && ar_stat.done
					&& !step_small && !last_iter) begin
				iter_q <= iter_q + rtdc_pkg::ITER_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rtdc_pkg::CFG_REF_RES: ref_q    <= cfg_data[rtdc_pkg::REF_W-1:0];
					rtdc_pkg::CFG_NOM_RES: nom_q    <= cfg_data[rtdc_pkg::NOM_W-1:0];
					rtdc_pkg::CFG_COEF_A:  coef_a_q <= cfg_data;
					rtdc_pkg::CFG_COEF_B:  coef_b_q <= cfg_data;
					rtdc_pkg::CFG_COEF_C:  coef_c_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rtdc_pkg::ST_IDLE: if (in_valid) code_q <= raw_code;
			rtdc_pkg::ST_RES1: prod_q <= code_q * $signed({1'b0, ref_q});
			rtdc_pkg::ST_RES2: begin
				res_q   <= res_next;
				below_q <= below_next;
				tq_q    <= -29'sd655360;
			end
			rtdc_pkg::ST_UXQ: begin
				if (up_big)            xq_q <= 28'd1 << 27;
				else if (ar_stat.done) xq_q <= ar_stat.result[27:0];
			end
			rtdc_pkg::ST_UAA: if (ar_stat.done) acc_q <= mulres;
			rtdc_pkg::ST_UBX: if (ar_stat.done) acc_q <= acc_q + (mulres <<< 2);
			rtdc_pkg::ST_UVTX: if (ar_stat.done) temp_q <= {1'b0, ar_stat.result[55:0]};
			rtdc_pkg::ST_USQ: if (ar_stat.done)
				acc_q <= $signed(64'(coef_a_q) + (64'(ar_stat.result[31:0]) << 5));
			rtdc_pkg::ST_UDEN: if (acc_q == '0)
				temp_q <= (xq_q == '0) ? 57'sd0 : 57'sd262144;
			rtdc_pkg::ST_UDIV: if (ar_stat.done) temp_q <= {1'b0, ar_stat.result[55:0]};
			rtdc_pkg::ST_LY: if (ar_stat.done) y_q <= -$signed({1'b0, ar_stat.result[50:0]});
			rtdc_pkg::ST_LT2: if (ar_stat.done) t2_q <= mulres[39:0];
			rtdc_pkg::ST_LT3: if (ar_stat.done) t3_q <= mulres[50:0];
			rtdc_pkg::ST_LT4: if (ar_stat.done) t4_q <= mulres[61:0];
			rtdc_pkg::ST_LG1: if (ar_stat.done) acc_q <= mulres;
			rtdc_pkg::ST_LG2, rtdc_pkg::ST_LG3, rtdc_pkg::ST_LD1:
				if (ar_stat.done) acc_q <= acc_q + mulres;
			rtdc_pkg::ST_LG4: if (ar_stat.done) begin
				g_q   <= acc_q - mulres - 64'(y_q);
				acc_q <= $signed(64'(coef_a_q) << 8);
			end
			rtdc_pkg::ST_LD2: if (ar_stat.done) dp_q <= acc_q + mulres;
			rtdc_pkg::ST_LSTEP: if (ar_stat.done) tq_q <= tq_next;
			rtdc_pkg::ST_LEND: temp_q <= 57'(t_rnd);
			default: ;
		endcase
		if (fin_load) begin
			out_res_q   <= res_q;
			out_below_q <= below_q;
			if (temp_q > 57'(rtdc_pkg::T_MAX)) begin
				out_temp_q <= rtdc_pkg::T_MAX;
				out_sat_q  <= 1'b1;
			end else if (temp_q < 57'(rtdc_pkg::T_MIN)) begin
				out_temp_q <= rtdc_pkg::T_MIN;
				out_sat_q  <= 1'b1;
			end else begin
				out_temp_q <= temp_q[rtdc_pkg::TEMP_W-1:0];
				out_sat_q  <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign resistance      = out_res_q;
	assign temperature     = out_temp_q;
	assign below_zero_path = out_below_q;
	assign saturated       = out_sat_q;

	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		ar_stat.done |-> issued_q)
		else $error("arithmetic result without a pending request");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= rtdc_pkg::ITER_W'(rtdc_pkg::NEWTON_STEPS - 1))
		else $error("Newton step count past its limit");

	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(temperature == rtdc_pkg::T_MAX || temperature == rtdc_pkg::T_MIN))
		else $error("clamp flag without a clamped temperature");

	a_upper_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !below_zero_path |-> !resistance[rtdc_pkg::RES_W-1])
		else $error("quadratic path with negative resistance");

endmodule
`default_nettype wire

>>> tb/sv/tb_rtd_code_to_temperature_unit.sv
// Testbench for the RTD code-to-temperature unit: directed and random codes vs a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_rtd_code_to_temperature_unit;

	typedef struct {
		logic signed [rtdc_pkg::RES_W-1:0]  res;
		logic signed [rtdc_pkg::TEMP_W-1:0] temp;
		logic                               below;
		logic                               sat;
	} rtd_result_t;

	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam logic signed [127:0] I64_MAX = (128'sd1 <<< 63) - 1;
	localparam logic signed [127:0] I64_MIN = -(128'sd1 <<< 63);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic signed [rtdc_pkg::CODE_BITS-1:0] raw_code = '0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [rtdc_pkg::COEF_W-1:0] cfg_data = '0;
	logic in_ready, out_valid, below_zero_path, saturated, cfg_ready;
	logic signed [rtdc_pkg::RES_W-1:0] resistance;
	logic signed [rtdc_pkg::TEMP_W-1:0] temperature;

	// shadow of the unit's registers
	logic [rtdc_pkg::REF_W-1:0]         m_ref = rtdc_pkg::REF_RST;
	logic [rtdc_pkg::NOM_W-1:0]         m_nom = rtdc_pkg::NOM_RST;
	logic [rtdc_pkg::COEF_W-1:0]        m_a   = rtdc_pkg::COEF_A_RST;
	logic signed [rtdc_pkg::COEF_W-1:0] m_b   = rtdc_pkg::COEF_B_RST;
	logic signed [rtdc_pkg::COEF_W-1:0] m_c   = rtdc_pkg::COEF_C_RST;

	rtd_result_t pending_temps[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	longint cycles = 0;

	rtd_code_to_temperature_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .raw_code(raw_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.resistance(resistance), .temperature(temperature),
		.below_zero_path(below_zero_path), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// floor(a*b / 2^s), saturated to 64 bits
	function automatic longint mul_floor(longint a, longint b, int s);
		logic signed [127:0] wa, wb, p;
		wa = 128'(a);
		wb = 128'(b);
		p = (wa * wb) >>> s;
		if (p > I64_MAX) p = I64_MAX;
		if (p < I64_MIN) p = I64_MIN;
		return longint'(p);
	endfunction

	function automatic logic [127:0] frac_div(logic [63:0] num, logic [63:0] den, int bits);
		logic [127:0] n;
		n = {64'd0, num};
		return (n << bits) / den;
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] abs64(longint v);
		logic [63:0] u;
		u = v;
		return v < 0 ? -u : u;
	endfunction

	function automatic rtd_result_t predict_temperature(
			logic signed [rtdc_pkg::CODE_BITS-1:0] code_in);
		rtd_result_t e;
		longint c, r0, a, b, cc, res, temp, d, xq, disc, den, y, tq, t2, t3, t4, g, dp;
		logic [63:0] ab, ag, adp, q, step;
		c = longint'(code_in);
		r0 = (m_nom != 0) ? longint'(m_nom) : 1;
		a = longint'(m_a);
		b = longint'(m_b);
		cc = longint'(m_c);
		res = (c * longint'(m_ref) + (64'sd1 <<< 22)) >>> 23;
		e.below = res < r0;
		e.sat = 1'b0;
		if (!e.below) begin
			d = res - r0;
			xq = (d >= 32 * r0) ? (64'sd1 <<< 27) : longint'(frac_div(d, r0, 22));
			disc = mul_floor(a, a, 10) + 4 * b * xq;
			if (disc < 0) begin
				ab = abs64(b);
				temp = longint'(((a <<< 15) + ab / 2) / ab);
			end else begin
				den = a + longint'(isqrt(disc) << 5);
				if (den == 0) temp = (xq == 0) ? 0 : longint'(rtdc_pkg::T_MAX) + 1;
				else temp = ((xq <<< 27) + den / 2) / den;
			end
		end else begin
			d = r0 - res;
			if (d > 4 * r0) d = 4 * r0;
			y = -longint'(frac_div(d, r0, 48));
			tq = -(64'sd10 <<< 16);
			for (int i = 0; i < rtdc_pkg::NEWTON_STEPS; i++) begin
				t2 = mul_floor(tq, tq, 16);
				t3 = mul_floor(t2, tq, 16);
				t4 = mul_floor(t3, tq, 16);
				g = mul_floor(a, tq, 8) + mul_floor(b, t2, 16) + mul_floor(cc, t4, 32)
					- mul_floor(cc, 100 * t3, 32) - y;
				dp = a * 256 + mul_floor(b, 2 * tq, 16) + mul_floor(cc, 4 * t3 - 300 * t2, 32);
				adp = abs64(dp);
				ag = abs64(g);
				if (adp < rtdc_pkg::DERIV_TINY) break;
				q = ag / adp;
				step = (q >= (64'd1 << 20)) ? (64'd1 << 36) : 64'(frac_div(ag, adp, 16));
				tq = ((g < 0) == (dp < 0)) ? tq - longint'(step) : tq + longint'(step);
				if (tq > (64'sd1 <<< 27)) tq = 64'sd1 <<< 27;
				if (tq < -(64'sd1 <<< 27)) tq = -(64'sd1 <<< 27);
				if (step <= 64'(rtdc_pkg::STEP_SMALL)) break;
			end
			temp = (tq + 128) >>> 8;
		end
		if (temp > longint'(rtdc_pkg::T_MAX)) begin
			temp = longint'(rtdc_pkg::T_MAX);
			e.sat = 1'b1;
		end
		if (temp < longint'(rtdc_pkg::T_MIN)) begin
			temp = longint'(rtdc_pkg::T_MIN);
			e.sat = 1'b1;
		end
		e.res = res[rtdc_pkg::RES_W-1:0];
		e.temp = temp[rtdc_pkg::TEMP_W-1:0];
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
		mismatches++;
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		rtd_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_temps.size() == 0) report_mismatch("unexpected beat", resistance, 0);
			else begin
				e = pending_temps.pop_front();
				if (resistance !== e.res) report_mismatch("resistance", resistance, e.res);
				if (temperature !== e.temp) report_mismatch("temperature", temperature, e.temp);
				if (below_zero_path !== e.below)
					report_mismatch("below_zero_path", below_zero_path, e.below);
				if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
			end
		end
	end

	// called at a falling edge; leaves the caller at a falling edge
	task automatic send_code(logic signed [rtdc_pkg::CODE_BITS-1:0] code);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_code <= code;
		do @(posedge clk); while (!in_ready);
		pending_temps.push_back(predict_temperature(code));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_temps.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(rtdc_pkg::cfg_idx_t idx, logic [rtdc_pkg::COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rtdc_pkg::CFG_REF_RES: m_ref = data[rtdc_pkg::REF_W-1:0];
			rtdc_pkg::CFG_NOM_RES: m_nom = data[rtdc_pkg::NOM_W-1:0];
			rtdc_pkg::CFG_COEF_A:  m_a = data;
			rtdc_pkg::CFG_COEF_B:  m_b = data;
			rtdc_pkg::CFG_COEF_C:  m_c = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_coefs(logic [rtdc_pkg::REF_W-1:0] rr, logic [rtdc_pkg::NOM_W-1:0] nr,
			logic [rtdc_pkg::COEF_W-1:0] a, logic [rtdc_pkg::COEF_W-1:0] b,
			logic [rtdc_pkg::COEF_W-1:0] c);
		write_reg(rtdc_pkg::CFG_REF_RES, rtdc_pkg::COEF_W'(rr));
		write_reg(rtdc_pkg::CFG_NOM_RES, rtdc_pkg::COEF_W'(nr));
		write_reg(rtdc_pkg::CFG_COEF_A, a);
		write_reg(rtdc_pkg::CFG_COEF_B, b);
		write_reg(rtdc_pkg::CFG_COEF_C, c);
	endtask

	// smallest code whose resistance reaches the target
	function automatic logic signed [rtdc_pkg::CODE_BITS-1:0] code_for_res(longint target);
		longint num, c;
		if (m_ref == 0) return rtdc_pkg::CODE_BITS'($urandom);
		num = target * (64'sd1 <<< 23) - (64'sd1 <<< 22);
		c = (num >= 0) ? (num + longint'(m_ref) - 1) / longint'(m_ref)
		               : num / longint'(m_ref);
		if (c > 8388607) c = 8388607;
		if (c < -8388608) c = -8388608;
		return c[rtdc_pkg::CODE_BITS-1:0];
	endfunction

	function automatic logic signed [rtdc_pkg::CODE_BITS-1:0] random_code();
		int pick;
		longint r0;
		pick = $urandom_range(99);
		r0 = (m_nom != 0) ? m_nom : 1;
		if (pick < 15) return rtdc_pkg::CODE_BITS'($urandom);
		if (pick < 30) return code_for_res(r0 + $urandom_range(8) - 4);
		return code_for_res(r0 / 4 + longint'($urandom_range(1000)) * r0 * 15 / 4000);
	endfunction

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && $urandom_range(1)) drain_results();
			send_code(random_code());
		end
		drain_results();
	endtask

	task automatic test_directed_defaults();
		longint r0;
		r0 = m_nom;
		send_code(24'sh000000);
		send_code(-24'sd1);
		send_code(24'sh7FFFFF);    // negative discriminant: vertex
		send_code(-24'sh800000);
		send_code(code_for_res(r0));      // exactly R0
		send_code(code_for_res(r0) - 24'sd1);
		send_code(code_for_res(r0 * 139 / 100));
		send_code(code_for_res(r0 * 8 / 10));
		send_code(code_for_res(r0 / 4));
		send_code(24'sh555555);
		send_code(24'shAAAAAA);
		drain_results();
	endtask

	task automatic test_register_extremes();
		load_coefs(0, rtdc_pkg::NOM_RST, rtdc_pkg::COEF_A_RST, rtdc_pkg::COEF_B_RST,
			rtdc_pkg::COEF_C_RST);
		send_code(24'sh7FFFFF);
		send_code(-24'sh800000);
		drain_results();
		load_coefs(24'hFFFFFF, 20'hFFFFF, rtdc_pkg::COEF_A_RST, rtdc_pkg::COEF_B_RST,
			rtdc_pkg::COEF_C_RST);
		send_code(24'sh7FFFFF);
		send_code(-24'sh800000);
		send_code(code_for_res(20'hFFFFF));
		drain_results();
		write_reg(rtdc_pkg::CFG_NOM_RES, 0);     // zero R0 acts as one
		send_code(24'sh7FFFFF);
		send_code(24'sh000001);
		drain_results();
		write_reg(rtdc_pkg::CFG_NOM_RES, 1);     // clamps high
		send_code(24'sh7FFFFF);
		drain_results();
		// zero denominator and tiny derivative
		load_coefs(rtdc_pkg::REF_RST, rtdc_pkg::NOM_RST, 0, 0, 0);
		send_code(code_for_res(rtdc_pkg::NOM_RST));
		send_code(code_for_res(rtdc_pkg::NOM_RST) + 24'sd50);
		send_code(code_for_res(rtdc_pkg::NOM_RST) - 24'sd50);
		drain_results();
		// lower path runs off to the clamp
		write_reg(rtdc_pkg::CFG_COEF_A, 1);
		send_code(code_for_res(rtdc_pkg::NOM_RST / 2));
		drain_results();
		load_coefs(rtdc_pkg::REF_RST, rtdc_pkg::NOM_RST, 33'h1FFFFFFFF, 33'h0FFFFFFFF,
			33'h0FFFFFFFF);
		send_code(24'sh7FFFFF);
		send_code(code_for_res(rtdc_pkg::NOM_RST / 2));
		drain_results();
		load_coefs(rtdc_pkg::REF_RST, rtdc_pkg::NOM_RST, rtdc_pkg::COEF_A_RST,
			33'h100000000, 33'h100000000);
		send_code(24'sh7FFFFF);
		send_code(code_for_res(rtdc_pkg::NOM_RST / 2));
		drain_results();
		load_coefs(rtdc_pkg::REF_RST, rtdc_pkg::NOM_RST, rtdc_pkg::COEF_A_RST,
			rtdc_pkg::COEF_B_RST, rtdc_pkg::COEF_C_RST);
	endtask

	task automatic test_random_traffic();
		int idle_mode[4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{6, 6}};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_mode[p][0];
			recv_stall_pct = idle_mode[p][1];
			random_burst(45);
		end
		// a few random register settings
		for (int k = 0; k < 3; k++) begin
			load_coefs(rtdc_pkg::REF_W'($urandom_range(24'hFFFFFF, 24'h100000)),
				rtdc_pkg::NOM_W'($urandom_range(20'hFFFFF, 50000)),
				rtdc_pkg::COEF_A_RST + $urandom_range(20000000) - 10000000,
				rtdc_pkg::COEF_B_RST + $urandom_range(40000000) - 20000000,
				rtdc_pkg::COEF_W'({$urandom, $urandom}));
			send_idle_pct = idle_mode[k][0];
			recv_stall_pct = idle_mode[k + 1][1];
			random_burst(35);
		end
		load_coefs(rtdc_pkg::REF_RST, rtdc_pkg::NOM_RST, rtdc_pkg::COEF_A_RST,
			rtdc_pkg::COEF_B_RST, rtdc_pkg::COEF_C_RST);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_defaults();
		test_register_extremes();
		test_random_traffic();
		drain_results();
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
hdl/rtdc_pkg.sv
hdl/rtdc_arith.sv
hdl/rtd_code_to_temperature_unit.sv
tb/sv/tb_rtd_code_to_temperature_unit.sv
